FILE: sv/assert_macros.svh
// Assertion helpers shared by the encoder modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Condition must never be true outside reset.
`define ASSERT_NEVER(name, clk, rst_n, cond) \
    `ASSERT_ALWAYS(name, clk, rst_n, (!(cond)))

`endif

FILE: sv/lcse_pkg.sv
package lcse_pkg;

    // Field widths.
    localparam int COMP_W = 8;
    localparam int HUE_W  = 11;
    localparam int GAP_W  = 6;
    localparam int ENC_W  = 3 * COMP_W;

    // Defaults for top level parameters.
    localparam int HUE_FRACTION_BITS_DEF = 8;
    localparam int QUEUE_DEPTH_DEF       = 2;

    // Configuration register.
    localparam logic             CFG_IDX_GAP = 1'b0;
    localparam logic [GAP_W-1:0] GAP_RESET   = 6'd20;
    localparam logic [GAP_W-1:0] GAP_MAX     = 6'd32;

    // Operation codes.
    localparam logic OP_RGB = 1'b0;
    localparam logic OP_HSV = 1'b1;

    // Full scale of a color fraction.
    localparam logic [COMP_W-1:0] FULL_SCALE = 8'd255;

    // Line patterns for one color bit.
    localparam logic [2:0] PULSE_ONE  = 3'b110;
    localparam logic [2:0] PULSE_ZERO = 3'b100;

    typedef struct packed {
        logic [COMP_W-1:0] red;
        logic [COMP_W-1:0] green;
        logic [COMP_W-1:0] blue;
    } color_t;

    // Exact x / 255 for x below 65280: reciprocal estimate plus one correction.
    function automatic logic [COMP_W-1:0] div255(input logic [15:0] x);
        logic [16:0] sum;
        logic [8:0]  quo;
        logic [16:0] prod;
        logic [16:0] rem;
        sum  = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
        quo  = sum[16:8];
        prod = {quo, 8'd0} - {8'd0, quo};
        rem  = {1'b0, x} - prod;
        if (rem >= 17'd255)
        begin
            quo = quo + 9'd1;
        end
        return quo[COMP_W-1:0];
    endfunction

    // Each color bit becomes three line bits, MSB first.
    function automatic logic [ENC_W-1:0] pulse_encode(input logic [COMP_W-1:0] c);
        logic [ENC_W-1:0] acc;
        acc = '0;
        for (int k = 0; k < COMP_W; k++)
        begin
            acc[3*k +: 3] = c[k] ? PULSE_ONE : PULSE_ZERO;
        end
        return acc;
    endfunction

endpackage

FILE: sv/led_color_spi_frame_encoder.sv
// A frame is gap + 10 bytes, one byte per cycle while out_ready is high;
// frames follow one another back to back while the queue holds a color.
// The byte-wide output register limits the color rate; the HSV pipeline takes one color
// a cycle unless the queue is full and its last stage holds a color.
// Reset (rst_n, asynchronous, active low) empties the queue and pipeline
// and sets the reset gap to 20 bytes.
module led_color_spi_frame_encoder #(
    parameter int HUE_FRACTION_BITS = lcse_pkg::HUE_FRACTION_BITS_DEF,
    parameter int QUEUE_DEPTH       = lcse_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [2:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        operation,
    input  logic [lcse_pkg::COMP_W-1:0] red_in,
    input  logic [lcse_pkg::COMP_W-1:0] green_in,
    input  logic [lcse_pkg::COMP_W-1:0] blue_in,
    input  logic [lcse_pkg::HUE_W-1:0]  hue,
    input  logic [lcse_pkg::COMP_W-1:0] saturation,
    input  logic [lcse_pkg::COMP_W-1:0] brightness,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [lcse_pkg::COMP_W-1:0] line_byte,
    output logic                        last
);
    import lcse_pkg::*;

    logic [GAP_W-1:0] gap_cfg_reg;
    logic [GAP_W-1:0] gap_len;
    logic             push;
    color_t           push_data;
    logic             full;
    logic             pop;
    color_t           pop_data;
    logic             empty;

    // Configuration register write and read back.
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_cfg_reg <= GAP_RESET;
        end
        else if (psel && penable && pwrite && (paddr[2] == CFG_IDX_GAP))
        begin
            gap_cfg_reg <= pwdata[GAP_W-1:0];
        end
    end

    assign prdata = (paddr[2] == CFG_IDX_GAP) ? {{(32-GAP_W){1'b0}}, gap_cfg_reg} : 32'd0;

    // Gap length saturates at the largest allowed run.
    assign gap_len = (gap_cfg_reg > GAP_MAX) ? GAP_MAX : gap_cfg_reg;

    lcse_front #(
        .HUE_FRACTION_BITS (HUE_FRACTION_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .operation  (operation),
        .red_in     (red_in),
        .green_in   (green_in),
        .blue_in    (blue_in),
        .hue        (hue),
        .saturation (saturation),
        .brightness (brightness),
        .push       (push),
        .push_data  (push_data),
        .full       (full)
    );

    lcse_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (empty)
    );

    lcse_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .gap_len   (gap_len),
        .empty     (empty),
        .pop_data  (pop_data),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .line_byte (line_byte),
        .last      (last)
    );

endmodule

FILE: sv/lcse_front.sv
module lcse_front #(
    parameter int HUE_FRACTION_BITS = lcse_pkg::HUE_FRACTION_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        operation,
    input  logic [lcse_pkg::COMP_W-1:0] red_in,
    input  logic [lcse_pkg::COMP_W-1:0] green_in,
    input  logic [lcse_pkg::COMP_W-1:0] blue_in,
    input  logic [lcse_pkg::HUE_W-1:0]  hue,
    input  logic [lcse_pkg::COMP_W-1:0] saturation,
    input  logic [lcse_pkg::COMP_W-1:0] brightness,
    output logic                        push,
    output lcse_pkg::color_t            push_data,
    input  logic                        full
);
    import lcse_pkg::*;

    localparam int FB  = HUE_FRACTION_BITS;
    localparam int FS  = 1 << FB;
    localparam int DEN = 255 * FS;
    localparam int TW  = COMP_W + FB;
    localparam int PW  = 2 * COMP_W + FB;

    typedef enum logic [2:0] {
        SEC_0 = 3'd0,
        SEC_1 = 3'd1,
        SEC_2 = 3'd2,
        SEC_3 = 3'd3,
        SEC_4 = 3'd4,
        SEC_5 = 3'd5
    } sector_t;

    // Stage A registers: hue split and saturation products.
    logic              a_valid_reg;
    logic              a_op_reg;
    color_t            a_rgb_reg;
    logic [COMP_W-1:0] a_v_reg;
    logic              a_szero_reg;
    sector_t           a_sector_reg;
    logic [COMP_W-1:0] a_pterm_reg;
    logic [TW-1:0]     a_qterm_reg;
    logic [TW-1:0]     a_tterm_reg;

    // Stage B registers: products with brightness.
    logic              b_valid_reg;
    logic              b_op_reg;
    color_t            b_rgb_reg;
    logic [COMP_W-1:0] b_v_reg;
    logic              b_szero_reg;
    sector_t           b_sector_reg;
    logic [15:0]       b_pprod_reg;
    logic [PW-1:0]     b_qprod_reg;
    logic [PW-1:0]     b_tprod_reg;

    logic                  advance;
    logic [HUE_W+FB-1:0]   hue_ext;
    logic [FB-1:0]         frac;
    logic [HUE_W-1:0]      sector_w;
    sector_t               sector_in;
    logic [FB:0]           frac_inv;
    logic [TW-1:0]         s_frac;
    logic [TW-1:0]         s_inv;
    logic [COMP_W-1:0]     p_val;
    logic [COMP_W-1:0]     q_val;
    logic [COMP_W-1:0]     t_val;
    color_t                hsv_rgb;

    // The whole pipeline stalls only when the last stage cannot push.
    assign advance  = !b_valid_reg || !full;
    assign in_ready = advance;
    assign push     = b_valid_reg && !full;

    // Split hue into sector and fraction; clamp sectors above five.
    assign hue_ext  = {{FB{1'b0}}, hue};
    assign frac     = hue_ext[FB-1:0];
    assign sector_w = hue_ext[FB +: HUE_W];
    assign sector_in = (sector_w > HUE_W'(5)) ? SEC_5 : sector_t'(sector_w[2:0]);
    assign frac_inv = (FB+1)'(FS) - {1'b0, frac};
    assign s_frac   = TW'(saturation) * TW'(frac);
    assign s_inv    = TW'(saturation) * TW'(frac_inv);

    // Stage A and B registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            a_op_reg     <= operation;
            a_rgb_reg    <= '{red: red_in, green: green_in, blue: blue_in};
            a_v_reg      <= brightness;
            a_szero_reg  <= (saturation == '0);
            a_sector_reg <= sector_in;
            a_pterm_reg  <= FULL_SCALE - saturation;
            a_qterm_reg  <= TW'(DEN) - s_frac;
            a_tterm_reg  <= TW'(DEN) - s_inv;

            b_op_reg     <= a_op_reg;
            b_rgb_reg    <= a_rgb_reg;
            b_v_reg      <= a_v_reg;
            b_szero_reg  <= a_szero_reg;
            b_sector_reg <= a_sector_reg;
            b_pprod_reg  <= 16'(a_v_reg) * 16'(a_pterm_reg);
            b_qprod_reg  <= PW'(a_v_reg) * PW'(a_qterm_reg);
            b_tprod_reg  <= PW'(a_v_reg) * PW'(a_tterm_reg);
        end
    end

    // Division by 255 (after the fraction shift) and sector selection.
    assign p_val = div255(b_pprod_reg);
    assign q_val = div255(b_qprod_reg[FB +: 16]);
    assign t_val = div255(b_tprod_reg[FB +: 16]);

    always_comb
    begin
        case (b_sector_reg)
            SEC_0:   hsv_rgb = '{red: b_v_reg, green: t_val,   blue: p_val};
            SEC_1:   hsv_rgb = '{red: q_val,   green: b_v_reg, blue: p_val};
            SEC_2:   hsv_rgb = '{red: p_val,   green: b_v_reg, blue: t_val};
            SEC_3:   hsv_rgb = '{red: p_val,   green: q_val,   blue: b_v_reg};
            SEC_4:   hsv_rgb = '{red: t_val,   green: p_val,   blue: b_v_reg};
            default: hsv_rgb = '{red: b_v_reg, green: p_val,   blue: q_val};
        endcase
    end

    // Pick the color source; zero saturation gives gray.
    always_comb
    begin
        if (b_op_reg == OP_RGB)
        begin
            push_data = b_rgb_reg;
        end
        else if (b_szero_reg)
        begin
            push_data = '{red: b_v_reg, green: b_v_reg, blue: b_v_reg};
        end
        else
        begin
            push_data = hsv_rgb;
        end
    end

endmodule

FILE: sv/lcse_fifo.sv
`include "assert_macros.svh"

module lcse_fifo #(
    parameter int DEPTH = lcse_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  lcse_pkg::color_t push_data,
    output logic             full,
    input  logic             pop,
    output lcse_pkg::color_t pop_data,
    output logic             empty
);
    import lcse_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    color_t             mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    `ASSERT_ALWAYS(a_count_bound, clk, rst_n, (count_reg <= CNT_W'(DEPTH)))
    `ASSERT_NEVER(a_push_full, clk, rst_n, push && full)

endmodule

FILE: sv/lcse_back.sv
`include "assert_macros.svh"

module lcse_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [lcse_pkg::GAP_W-1:0]  gap_len,
    input  logic                        empty,
    input  lcse_pkg::color_t            pop_data,
    output logic                        pop,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [lcse_pkg::COMP_W-1:0] line_byte,
    output logic                        last
);
    import lcse_pkg::*;

    localparam int FRAME_W = 3 * ENC_W;
    localparam logic [GAP_W-1:0] DATA_LAST = GAP_W'(3 * ENC_W / COMP_W - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_GAP,
        ST_DATA,
        ST_TAIL
    } state_t;

    state_t               state_reg, state_next;
    logic [GAP_W-1:0]     cnt_reg, cnt_next;
    logic [FRAME_W-1:0]   frame_reg, frame_next;
    logic                 out_valid_reg, out_valid_next;
    logic [COMP_W-1:0]    line_byte_reg, line_byte_next;
    logic                 last_reg, last_next;
    logic                 load;

    // The output register can take a new word when empty or being drained.
    assign load = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        frame_next     = frame_reg;
        out_valid_next = out_valid_reg && !out_ready;
        line_byte_next = line_byte_reg;
        last_next      = last_reg;
        pop            = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (!empty)
                begin
                    pop = 1'b1;
                end
            end
            ST_GAP:
            begin
                if (load)
                begin
                    out_valid_next = 1'b1;
                    line_byte_next = '0;
                    last_next      = 1'b0;
                    if (cnt_reg == GAP_W'(1))
                    begin
                        state_next = ST_DATA;
                        cnt_next   = '0;
                    end
                    else
                    begin
                        cnt_next = cnt_reg - 1'b1;
                    end
                end
            end
            ST_DATA:
            begin
                if (load)
                begin
                    out_valid_next = 1'b1;
                    line_byte_next = frame_reg[FRAME_W-1 -: COMP_W];
                    last_next      = 1'b0;
                    frame_next     = {frame_reg[FRAME_W-COMP_W-1:0], {COMP_W{1'b0}}};
                    if (cnt_reg == DATA_LAST)
                    begin
                        state_next = ST_TAIL;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end
            ST_TAIL:
            begin
                if (load)
                begin
                    out_valid_next = 1'b1;
                    line_byte_next = '0;
                    last_next      = 1'b1;
                    if (!empty)
                    begin
                        pop = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Start the next frame straight from the queue head.
        if (pop)
        begin
            frame_next = {pulse_encode(pop_data.green), pulse_encode(pop_data.red),
                          pulse_encode(pop_data.blue)};
            if (gap_len != '0)
            begin
                state_next = ST_GAP;
                cnt_next   = gap_len;
            end
            else
            begin
                state_next = ST_DATA;
                cnt_next   = '0;
            end
        end
    end

    // State and output word registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            last_reg      <= 1'b0;
            frame_reg     <= '0;
            line_byte_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            last_reg      <= last_next;
            frame_reg     <= frame_next;
            line_byte_reg <= line_byte_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign line_byte = line_byte_reg;
    assign last      = last_reg;

    `ASSERT_NEVER(a_pop_empty, clk, rst_n, pop && empty)
    `ASSERT_ALWAYS(a_gap_count, clk, rst_n, (state_reg == ST_GAP |-> cnt_reg != '0))
    `ASSERT_ALWAYS(a_data_count, clk, rst_n, (state_reg == ST_DATA |-> cnt_reg <= DATA_LAST))

endmodule

FILE: bench/led_color_spi_frame_encoder_tb.sv
`timescale 1ns / 1ps

module led_color_spi_frame_encoder_tb;

    import lcse_pkg::*;

    localparam int HUE_FRAC     = HUE_FRACTION_BITS_DEF;
    localparam int LIMIT_CYCLES = 400000;
    localparam int SETTLE       = 8;
    localparam logic [2:0] ADDR_GAP   = 3'd0;
    localparam logic [2:0] ADDR_SPARE = 3'd4;

    // One requested LED color as presented on the input channel.
    typedef struct {
        logic              op;
        logic [COMP_W-1:0] red;
        logic [COMP_W-1:0] green;
        logic [COMP_W-1:0] blue;
        logic [HUE_W-1:0]  hue;
        logic [COMP_W-1:0] sat;
        logic [COMP_W-1:0] val;
    } color_req_t;

    // One line byte as it should leave the block.
    typedef struct {
        logic [COMP_W-1:0] data;
        logic              tail;
    } line_word_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    logic              in_valid = 1'b0;
    logic              in_ready;
    logic              operation = OP_RGB;
    logic [COMP_W-1:0] red_in = '0;
    logic [COMP_W-1:0] green_in = '0;
    logic [COMP_W-1:0] blue_in = '0;
    logic [HUE_W-1:0]  hue = '0;
    logic [COMP_W-1:0] saturation = '0;
    logic [COMP_W-1:0] brightness = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [COMP_W-1:0] line_byte;
    logic              last;

    color_req_t pending_colors[$];
    line_word_t expected_bytes[$];
    color_req_t offered;
    logic [GAP_W-1:0] gap_setting = GAP_RESET;

    int error_count = 0;
    int items_accepted = 0;
    int cycle_count = 0;
    int gap_left = 0;
    int burst_left = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    int stall_mode = 0;
    int mode_left = 0;

    led_color_spi_frame_encoder u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .operation  (operation),
        .red_in     (red_in),
        .green_in   (green_in),
        .blue_in    (blue_in),
        .hue        (hue),
        .saturation (saturation),
        .brightness (brightness),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .line_byte  (line_byte),
        .last       (last)
    );

    always #6 clk = ~clk;

    // Fixed-point HSV to RGB; sectors past the last one behave like the last.
    function automatic color_t hsv_to_rgb(input logic [HUE_W-1:0] h,
                                          input logic [COMP_W-1:0] s_in,
                                          input logic [COMP_W-1:0] v_in);
        int unsigned fs;
        int unsigned sector;
        int unsigned f;
        int unsigned den;
        int unsigned s;
        int unsigned v;
        int unsigned p;
        int unsigned q;
        int unsigned t;
        color_t c;
        fs = 1 << HUE_FRAC;
        sector = 32'(h) >> HUE_FRAC;
        f = 32'(h) & (fs - 1);
        den = 255 * fs;
        s = 32'(s_in);
        v = 32'(v_in);
        if (s == 0)
        begin
            c.red = v_in;
            c.green = v_in;
            c.blue = v_in;
            return c;
        end
        p = (v * (255 - s)) / 255;
        q = (v * (den - s * f)) / den;
        t = (v * (den - s * (fs - f))) / den;
        case (sector)
            0: begin c.red = v_in; c.green = COMP_W'(t); c.blue = COMP_W'(p); end
            1: begin c.red = COMP_W'(q); c.green = v_in; c.blue = COMP_W'(p); end
            2: begin c.red = COMP_W'(p); c.green = v_in; c.blue = COMP_W'(t); end
            3: begin c.red = COMP_W'(p); c.green = COMP_W'(q); c.blue = v_in; end
            4: begin c.red = COMP_W'(t); c.green = COMP_W'(p); c.blue = v_in; end
            default: begin c.red = v_in; c.green = COMP_W'(p); c.blue = COMP_W'(q); end
        endcase
        return c;
    endfunction

    // Expand one component into its three pulse bytes, MSB first.
    task automatic push_component(input logic [COMP_W-1:0] comp);
        logic [ENC_W-1:0] enc;
        enc = '0;
        for (int k = COMP_W - 1; k >= 0; k--)
        begin
            enc = {enc[ENC_W-4:0], (comp[k] ? PULSE_ONE : PULSE_ZERO)};
        end
        expected_bytes.push_back('{enc[23:16], 1'b0});
        expected_bytes.push_back('{enc[15:8], 1'b0});
        expected_bytes.push_back('{enc[7:0], 1'b0});
    endtask

    // Queue the whole byte stream that one accepted color should produce.
    task automatic predict_frame(input color_req_t req);
        color_t c;
        int unsigned gap;
        if (req.op == OP_RGB)
        begin
            c.red = req.red;
            c.green = req.green;
            c.blue = req.blue;
        end
        else
        begin
            c = hsv_to_rgb(req.hue, req.sat, req.val);
        end
        gap = (gap_setting > GAP_MAX) ? 32'(GAP_MAX) : 32'(gap_setting);
        for (int i = 0; i < gap; i++)
        begin
            expected_bytes.push_back('{8'h00, 1'b0});
        end
        push_component(c.green);
        push_component(c.red);
        push_component(c.blue);
        expected_bytes.push_back('{8'h00, 1'b1});
    endtask

    function automatic color_req_t mk_color(input logic op,
                                            input logic [COMP_W-1:0] r,
                                            input logic [COMP_W-1:0] g,
                                            input logic [COMP_W-1:0] b,
                                            input logic [HUE_W-1:0] h,
                                            input logic [COMP_W-1:0] s,
                                            input logic [COMP_W-1:0] v);
        color_req_t req;
        req.op = op;
        req.red = r;
        req.green = g;
        req.blue = b;
        req.hue = h;
        req.sat = s;
        req.val = v;
        return req;
    endfunction

    // Mostly uniform, with extra weight on full-scale corners.
    function automatic logic [COMP_W-1:0] rand_level();
        if ($urandom_range(0, 7) == 0)
        begin
            return $urandom_range(0, 1) ? 8'd255 : 8'd0;
        end
        return COMP_W'($urandom_range(0, 255));
    endfunction

    function automatic color_req_t rand_color();
        color_req_t req;
        int pick;
        req.op = $urandom_range(0, 1) ? OP_HSV : OP_RGB;
        req.red = rand_level();
        req.green = rand_level();
        req.blue = rand_level();
        pick = $urandom_range(0, 15);
        if (pick == 0)
        begin
            req.hue = HUE_W'($urandom_range(1536, 2047));
        end
        else if (pick == 1)
        begin
            req.hue = HUE_W'(($urandom_range(0, 5) << HUE_FRAC) |
                             ($urandom_range(0, 1) ? 255 : 0));
        end
        else
        begin
            req.hue = HUE_W'($urandom_range(0, 1535));
        end
        req.sat = rand_level();
        req.val = rand_level();
        return req;
    endfunction

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if ((addr >> 2) == CFG_IDX_GAP)
        begin
            gap_setting = data[GAP_W-1:0];
        end
    endtask

    // Read back the gap register and compare against the local copy.
    task automatic check_gap_reg();
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= ADDR_GAP;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        if (prdata[GAP_W-1:0] !== gap_setting)
        begin
            $error("prdata mismatch: expected %0d, got %0d", gap_setting,
                   prdata[GAP_W-1:0]);
            error_count++;
        end
    endtask

    // Let the block drain completely before going on.
    // The check runs on the falling edge, after the driver has settled.
    task automatic wait_idle();
        while (pending_colors.size() != 0 || in_valid || expected_bytes.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic run_random(input int count);
        for (int i = 0; i < count; i++)
        begin
            pending_colors.push_back(rand_color());
        end
        wait_idle();
    endtask

    // Color driver: bursts of random length separated by random gaps.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                predict_frame(offered);
                items_accepted <= items_accepted + 1;
            end
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_colors.size() > 0)
                begin
                    offered = pending_colors.pop_front();
                    operation <= offered.op;
                    red_in <= offered.red;
                    green_in <= offered.green;
                    blue_in <= offered.blue;
                    hue <= offered.hue;
                    saturation <= offered.sat;
                    brightness <= offered.val;
                    in_valid <= 1'b1;
                    if (burst_left > 1)
                    begin
                        burst_left--;
                    end
                    else if ($urandom_range(0, 3) == 0)
                    begin
                        burst_left = 30;
                        gap_left = 0;
                    end
                    else
                    begin
                        burst_left = $urandom_range(1, 12);
                        gap_left = $urandom_range(0, 15);
                    end
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Line receiver: stall modes change at random, plus one long hold-off.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (!hold_done && items_accepted >= 60)
            begin
                hold_done = 1'b1;
                hold_left = 400;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    stall_mode = $urandom_range(0, 3);
                    mode_left = $urandom_range(32, 256);
                end
                else
                begin
                    mode_left--;
                end
                case (stall_mode)
                    0: out_ready <= 1'b1;
                    1: out_ready <= 1'($urandom_range(0, 1));
                    2: out_ready <= ($urandom_range(0, 3) == 0);
                    default: out_ready <= ~out_ready;
                endcase
            end
        end
    end

    // Compare every line word taken from the block with the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_bytes.size() == 0)
            begin
                $error("unexpected word: line_byte %h, last %b", line_byte, last);
                error_count++;
            end
            else
            begin
                line_word_t exp_word;
                exp_word = expected_bytes.pop_front();
                if (line_byte !== exp_word.data)
                begin
                    $error("line_byte mismatch: expected %h, got %h", exp_word.data,
                           line_byte);
                    error_count++;
                end
                if (last !== exp_word.tail)
                begin
                    $error("last mismatch: expected %b, got %b", exp_word.tail, last);
                    error_count++;
                end
            end
        end
    end

    // Watchdog against a hung handshake.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        check_gap_reg();

        // Directed colors: extremes, every sector, gray and black.
        pending_colors.push_back(mk_color(OP_RGB, 8'h00, 8'h00, 8'h00, 11'd0, 8'd0, 8'd0));
        pending_colors.push_back(mk_color(OP_RGB, 8'hFF, 8'hFF, 8'hFF, 11'h7FF, 8'hFF, 8'hFF));
        pending_colors.push_back(mk_color(OP_RGB, 8'hAA, 8'h55, 8'h0F, 11'h555, 8'h3C, 8'hC3));
        pending_colors.push_back(mk_color(OP_RGB, 8'h01, 8'h80, 8'hFE, 11'h2AA, 8'h00, 8'h00));
        pending_colors.push_back(mk_color(OP_HSV, 8'h12, 8'h34, 8'h56, 11'd700, 8'd0, 8'd200));
        pending_colors.push_back(mk_color(OP_HSV, 8'hFF, 8'h00, 8'hFF, 11'd300, 8'd255, 8'd0));
        pending_colors.push_back(mk_color(OP_HSV, 8'h00, 8'h00, 8'h00, 11'd0, 8'd255, 8'd255));
        pending_colors.push_back(mk_color(OP_HSV, 8'h00, 8'h00, 8'h00, 11'd128, 8'd255, 8'd255));
        pending_colors.push_back(mk_color(OP_HSV, 8'h00, 8'h00, 8'h00, 11'd256, 8'd255, 8'd255));
        pending_colors.push_back(mk_color(OP_HSV, 8'h00, 8'h00, 8'h00, 11'd511, 8'd255, 8'd255));
        pending_colors.push_back(mk_color(OP_HSV, 8'h00, 8'h00, 8'h00, 11'd512, 8'd255, 8'd255));
        pending_colors.push_back(mk_color(OP_HSV, 8'h00, 8'h00, 8'h00, 11'd768, 8'd255, 8'd255));
        pending_colors.push_back(mk_color(OP_HSV, 8'h00, 8'h00, 8'h00, 11'd1024, 8'd255, 8'd255));
        pending_colors.push_back(mk_color(OP_HSV, 8'h00, 8'h00, 8'h00, 11'd1280, 8'd255, 8'd255));
        pending_colors.push_back(mk_color(OP_HSV, 8'h00, 8'h00, 8'h00, 11'd1535, 8'd255, 8'd255));
        // Hue codes past the sixth sector, then small saturation, small brightness and a mid case.
        pending_colors.push_back(mk_color(OP_HSV, 8'h00, 8'h00, 8'h00, 11'd1536, 8'd200, 8'd180));
        pending_colors.push_back(mk_color(OP_HSV, 8'h00, 8'h00, 8'h00, 11'd2047, 8'd255, 8'd255));
        pending_colors.push_back(mk_color(OP_HSV, 8'h00, 8'h00, 8'h00, 11'd1000, 8'd1, 8'd255));
        pending_colors.push_back(mk_color(OP_HSV, 8'h00, 8'h00, 8'h00, 11'd900, 8'd255, 8'd1));
        pending_colors.push_back(mk_color(OP_HSV, 8'h00, 8'h00, 8'h00, 11'd383, 8'd128, 8'd128));
        wait_idle();

        // No reset gap at all.
        apb_write(ADDR_GAP, 32'd0);
        check_gap_reg();
        run_random(30);

        // Longest legal gap; the long receiver hold-off lands here.
        apb_write(ADDR_GAP, {26'd0, GAP_MAX});
        check_gap_reg();
        run_random(25);

        // Over-range gap saturates; noise in the upper data bits is dropped,
        // and a write past the only register changes nothing.
        apb_write(ADDR_GAP, ($urandom & 32'hFFFF_FFC0) | 32'd63);
        apb_write(ADDR_SPARE, 32'd5);
        check_gap_reg();
        run_random(20);

        apb_write(ADDR_GAP, $urandom_range(1, 31));
        check_gap_reg();
        run_random(30);

        apb_write(ADDR_GAP, $urandom_range(0, 63));
        check_gap_reg();
        run_random(25);

        repeat (20) @(posedge clk);
        if (error_count == 0 && expected_bytes.size() == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
